// ===== hw/rtl/fssc_pkg.sv =====
package fssc_pkg;

    // width of the internal sequence counters and compares
    localparam int SEQ_WIDTH = 32;
    // fixed field widths
    localparam int FIELD_SEQ_W = 32;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 72;

    typedef logic [SEQ_WIDTH-1:0]   seq_t;
    typedef logic [FIELD_SEQ_W-1:0] field_seq_t;

    // received message type codes (7 is treated as other)
    typedef enum logic [2:0] {
        MSG_HEARTBEAT  = 3'd0,
        MSG_TEST_REQ   = 3'd1,
        MSG_RESEND_REQ = 3'd2,
        MSG_SEQ_RESET  = 3'd3,
        MSG_LOGOUT     = 3'd4,
        MSG_LOGON      = 3'd5,
        MSG_OTHER      = 3'd6
    } msg_code_t;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_REJECT      = 3'd1,
        ACT_DISCONNECT  = 3'd2,
        ACT_SEND_LOGON  = 3'd3,
        ACT_SEND_HBEAT  = 3'd4,
        ACT_RESET_SEQ   = 3'd5,
        ACT_SEND_RESEND = 3'd6,
        ACT_PROCESS_APP = 3'd7
    } action_t;

    typedef enum logic [3:0] {
        RSN_MISSING_TYPE  = 4'd0,
        RSN_MISSING_SEQ   = 4'd1,
        RSN_FIRST_NOT_LOG = 4'd2,
        RSN_LOGON         = 4'd3,
        RSN_HEARTBEAT     = 4'd4,
        RSN_TEST_REQ      = 4'd5,
        RSN_RESEND_REQ    = 4'd6,
        RSN_SEQ_RESET     = 4'd7,
        RSN_RESET_NO_NEW  = 4'd8,
        RSN_LOGOUT        = 4'd9,
        RSN_APPLICATION   = 4'd10,
        RSN_GAP           = 4'd11,
        RSN_DUP_IGNORED   = 4'd12,
        RSN_SEQ_TOO_LOW   = 4'd13,
        RSN_SENT_ACK      = 4'd14
    } reason_t;

    // one decoded input item
    typedef struct packed {
        logic       mode;
        logic       has_msg_code;
        logic [2:0] msg_code;
        logic       has_seq_num;
        field_seq_t seq_num;
        logic       has_new_seq;
        field_seq_t new_seq;
        logic       poss_dup;
    } in_item_t;

    // one result item
    typedef struct packed {
        action_t    action;
        field_seq_t action_seq;
        reason_t    reason;
        field_seq_t out_seq;
    } result_t;

    // sign-extend a field to 64 bits, then cut to the counter width
    function automatic seq_t to_seq(input field_seq_t v);
        logic [63:0] w;
        w = {{(64 - FIELD_SEQ_W){v[FIELD_SEQ_W-1]}}, v};
        return w[SEQ_WIDTH-1:0];
    endfunction

    // low field bits of a counter value, zero-filled when the counter is narrow
    function automatic field_seq_t to_field(input seq_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_SEQ_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/fssc_in_reg.sv =====
module fssc_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fssc_pkg::in_item_t in_item,
    output logic              item_valid,
    input  logic              item_take,
    output fssc_pkg::in_item_t item
);
    import fssc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // take a new item whenever the held one is empty or leaves this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/fssc_session.sv =====
module fssc_session (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_fire,
    input  fssc_pkg::in_item_t item,
    output fssc_pkg::result_t  result
);
    import fssc_pkg::*;

    logic      logged_on_reg;
    logic      logged_on_next;
    seq_t      expected_reg;
    seq_t      expected_next;
    seq_t      out_seq_reg;
    seq_t      out_seq_next;
    seq_t      sn;
    seq_t      ns;
    action_t   act;
    seq_t      aseq;
    reason_t   rsn;
    msg_code_t mtype;

    assign sn    = to_seq(item.seq_num);
    assign ns    = to_seq(item.new_seq);
    assign mtype = msg_code_t'(item.msg_code);

    // session decision and next state
    always_comb begin
        logged_on_next = logged_on_reg;
        expected_next  = expected_reg;
        out_seq_next   = out_seq_reg;
        act            = ACT_NONE;
        aseq           = '0;
        rsn            = RSN_SENT_ACK;
        if (item.mode) begin
            out_seq_next = out_seq_reg + seq_t'(1);
            rsn          = RSN_SENT_ACK;
        end else if (!item.has_msg_code) begin
            act = ACT_REJECT;
            rsn = RSN_MISSING_TYPE;
        end else if (!item.has_seq_num) begin
            act = ACT_REJECT;
            rsn = RSN_MISSING_SEQ;
        end else if (!logged_on_reg) begin
            if (mtype != MSG_LOGON) begin
                act = ACT_DISCONNECT;
                rsn = RSN_FIRST_NOT_LOG;
            end else begin
                logged_on_next = 1'b1;
                expected_next  = sn + seq_t'(1);
                act            = ACT_SEND_LOGON;
                aseq           = sn;
                rsn            = RSN_LOGON;
            end
        end else if (sn == expected_reg) begin
            // in order: advance, then dispatch by type
            expected_next = expected_reg + seq_t'(1);
            case (mtype)
                MSG_HEARTBEAT: begin
                    act = ACT_NONE;
                    rsn = RSN_HEARTBEAT;
                end
                MSG_TEST_REQ: begin
                    act  = ACT_SEND_HBEAT;
                    aseq = sn;
                    rsn  = RSN_TEST_REQ;
                end
                MSG_RESEND_REQ: begin
                    act  = ACT_RESET_SEQ;
                    aseq = sn;
                    rsn  = RSN_RESEND_REQ;
                end
                MSG_SEQ_RESET: begin
                    if (item.has_new_seq) begin
                        expected_next = ns;
                        act           = ACT_NONE;
                        aseq          = ns;
                        rsn           = RSN_SEQ_RESET;
                    end else begin
                        act = ACT_REJECT;
                        rsn = RSN_RESET_NO_NEW;
                    end
                end
                MSG_LOGOUT: begin
                    logged_on_next = 1'b0;
                    act            = ACT_DISCONNECT;
                    rsn            = RSN_LOGOUT;
                end
                default: begin
                    act = ACT_PROCESS_APP;
                    rsn = RSN_APPLICATION;
                end
            endcase
        end else if ($signed(sn) > $signed(expected_reg)) begin
            act  = ACT_SEND_RESEND;
            aseq = expected_reg;
            rsn  = RSN_GAP;
        end else if (item.poss_dup) begin
            act = ACT_NONE;
            rsn = RSN_DUP_IGNORED;
        end else begin
            act = ACT_DISCONNECT;
            rsn = RSN_SEQ_TOO_LOW;
        end
    end

    // session state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logged_on_reg <= 1'b0;
            expected_reg  <= '0;
            out_seq_reg   <= seq_t'(1);
        end else if (item_fire) begin
            logged_on_reg <= logged_on_next;
            expected_reg  <= expected_next;
            out_seq_reg   <= out_seq_next;
        end
    end

    assign result.action     = act;
    assign result.action_seq = to_field(aseq);
    assign result.reason     = rsn;
    assign result.out_seq    = to_field(out_seq_next);

endmodule

// ===== hw/rtl/fix_session_sequence_check_top.sv =====
// FIX session sequence check. Each input item is either a decoded summary of a
// received message or a notice that an outgoing message was sent, and each
// gives exactly one result item: an action, the sequence value attached to it,
// a reason code and the next outgoing sequence number. The block takes one
// item per clock cycle when the result side keeps up; an item passes an input
// register and the session logic, then its result is loaded into the result
// register as soon as that register is empty or being read. The session state
// (logged-on flag, expected incoming and next outgoing sequence numbers) is
// updated in the same cycle that the result is registered, so back-to-back
// items always see the state left by the one before. After reset the session
// is logged off and the outgoing count is 1.
module fix_session_sequence_check_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // has_msg_code, msg_code[2:0], has_seq_num, seq_num[31:0], has_new_seq,
    // new_seq[31:0], poss_dup, zero fill
    input  logic [fssc_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // action[2:0], action_seq[31:0], reason[3:0], out_seq[31:0], zero fill
    output logic [fssc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import fssc_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     item_fire;
    logic     out_load;
    result_t  result;
    result_t  result_reg;
    logic     m_valid_reg;
    logic     m_valid_next;

    // unpack the input item
    assign in_item.mode         = s_tuser;
    assign in_item.has_msg_code = s_tdata[0];
    assign in_item.msg_code     = s_tdata[3:1];
    assign in_item.has_seq_num  = s_tdata[4];
    assign in_item.seq_num      = s_tdata[36:5];
    assign in_item.has_new_seq  = s_tdata[37];
    assign in_item.new_seq      = s_tdata[69:38];
    assign in_item.poss_dup     = s_tdata[70];

    fssc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (out_load),
        .item       (item)
    );

    // result register frees up when empty or taken this cycle
    assign out_load  = !m_valid_reg || m_tready;
    assign item_fire = item_valid && out_load;

    fssc_session u_session (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (item_fire),
        .item      (item),
        .result    (result)
    );

    assign m_valid_next = out_load ? item_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (item_fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, result_reg.out_seq, result_reg.reason,
                       result_reg.action_seq, result_reg.action};

endmodule

// ===== tb/sv/fssc_session_checker.sv =====
module fssc_session_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // has_msg_code, msg_code[2:0], has_seq_num, seq_num[31:0], has_new_seq,
    // new_seq[31:0], poss_dup, zero fill
    input  logic [fssc_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // action[2:0], action_seq[31:0], reason[3:0], out_seq[31:0], zero fill
    input  logic [fssc_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                               fail_count,
    output int                               pending,
    output int                               items_in,
    output int                               results_out,
    output logic [15:0]                      reasons_hit
);
    timeunit 1ns;
    timeprecision 1ps;
    import fssc_pkg::*;

    // predicted session state
    logic    logged_on;
    seq_t    in_ctr;
    seq_t    out_ctr;

    result_t expected_q[$];
    result_t want;
    in_item_t rx_item;

    initial begin
        fail_count  = 0;
        pending     = 0;
        items_in    = 0;
        results_out = 0;
        reasons_hit = '0;
    end

    // session outcome of one item, advancing the predicted state
    function automatic result_t session_step(input in_item_t it);
        result_t r;
        seq_t    sn;
        seq_t    ns;
        seq_t    aseq;
        sn       = seq_t'($signed(it.seq_num));
        ns       = seq_t'($signed(it.new_seq));
        aseq     = '0;
        r.action = ACT_NONE;
        r.reason = RSN_SENT_ACK;
        if (it.mode) begin
            out_ctr  = out_ctr + 1'b1;
            r.reason = RSN_SENT_ACK;
        end else if (!it.has_msg_code) begin
            r.action = ACT_REJECT;
            r.reason = RSN_MISSING_TYPE;
        end else if (!it.has_seq_num) begin
            r.action = ACT_REJECT;
            r.reason = RSN_MISSING_SEQ;
        end else if (!logged_on) begin
            if (it.msg_code != MSG_LOGON) begin
                r.action = ACT_DISCONNECT;
                r.reason = RSN_FIRST_NOT_LOG;
            end else begin
                logged_on = 1'b1;
                in_ctr    = sn + 1'b1;
                r.action  = ACT_SEND_LOGON;
                aseq      = sn;
                r.reason  = RSN_LOGON;
            end
        end else if (sn == in_ctr) begin
            // in order: advance, then dispatch by type
            in_ctr = in_ctr + 1'b1;
            case (it.msg_code)
                MSG_HEARTBEAT: begin
                    r.reason = RSN_HEARTBEAT;
                end
                MSG_TEST_REQ: begin
                    r.action = ACT_SEND_HBEAT;
                    aseq     = sn;
                    r.reason = RSN_TEST_REQ;
                end
                MSG_RESEND_REQ: begin
                    r.action = ACT_RESET_SEQ;
                    aseq     = sn;
                    r.reason = RSN_RESEND_REQ;
                end
                MSG_SEQ_RESET: begin
                    if (it.has_new_seq) begin
                        in_ctr   = ns;
                        aseq     = ns;
                        r.reason = RSN_SEQ_RESET;
                    end else begin
                        r.action = ACT_REJECT;
                        r.reason = RSN_RESET_NO_NEW;
                    end
                end
                MSG_LOGOUT: begin
                    logged_on = 1'b0;
                    r.action  = ACT_DISCONNECT;
                    r.reason  = RSN_LOGOUT;
                end
                default: begin
                    r.action = ACT_PROCESS_APP;
                    r.reason = RSN_APPLICATION;
                end
            endcase
        end else if ($signed(sn) > $signed(in_ctr)) begin
            r.action = ACT_SEND_RESEND;
            aseq     = in_ctr;
            r.reason = RSN_GAP;
        end else if (it.poss_dup) begin
            r.reason = RSN_DUP_IGNORED;
        end else begin
            r.action = ACT_DISCONNECT;
            r.reason = RSN_SEQ_TOO_LOW;
        end
        r.action_seq = field_seq_t'(aseq);
        r.out_seq    = field_seq_t'(out_ctr);
        return r;
    endfunction

    // predict on each accepted input item, compare each accepted result item
    always @(posedge aclk) begin
        if (!aresetn) begin
            logged_on = 1'b0;
            in_ctr    = '0;
            out_ctr   = seq_t'(1);
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                rx_item.mode         = s_tuser;
                rx_item.has_msg_code = s_tdata[0];
                rx_item.msg_code     = s_tdata[3:1];
                rx_item.has_seq_num  = s_tdata[4];
                rx_item.seq_num      = s_tdata[36:5];
                rx_item.has_new_seq  = s_tdata[37];
                rx_item.new_seq      = s_tdata[69:38];
                rx_item.poss_dup     = s_tdata[70];
                expected_q.push_back(session_step(rx_item));
                items_in++;
            end
            if (m_tvalid && m_tready) begin
                results_out++;
                reasons_hit[m_tdata[38:35]] = 1'b1;
                if (expected_q.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[2:0] !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[34:3] !== want.action_seq) begin
                        $error("action_seq: expected %h, got %h",
                               want.action_seq, m_tdata[34:3]);
                        fail_count++;
                    end
                    if (m_tdata[38:35] !== want.reason) begin
                        $error("reason: expected %0d, got %0d", want.reason, m_tdata[38:35]);
                        fail_count++;
                    end
                    if (m_tdata[70:39] !== want.out_seq) begin
                        $error("out_seq: expected %h, got %h", want.out_seq, m_tdata[70:39]);
                        fail_count++;
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/sv/fix_session_sequence_check_top_test.sv =====
module fix_session_sequence_check_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fssc_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         ITEMS_PER_PHASE = 150;
    // type code outside the named set, handled as other
    localparam logic [2:0] MSG_UNLISTED = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // has_msg_code, msg_code[2:0], has_seq_num, seq_num[31:0], has_new_seq,
    // new_seq[31:0], poss_dup, zero fill
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // mode
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // action[2:0], action_seq[31:0], reason[3:0], out_seq[31:0], zero fill
    logic [M_TDATA_W-1:0] m_tdata;

    int          fail_count;
    int          pending;
    int          items_in;
    int          results_out;
    logic [15:0] reasons_hit;

    int          tx_idle_pct = 26;
    int          rx_stall_pct = 85;
    int          idle_cycles = 0;

    // session as the stimulus expects it, used to aim sequence numbers
    logic        sess_on = 1'b0;
    field_seq_t  sess_next = '0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    fix_session_sequence_check_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fssc_session_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .items_in    (items_in),
        .results_out (results_out),
        .reasons_hit (reasons_hit)
    );

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // stop the run if nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d cycles without progress", idle_cycles);
                $display("fix_session_sequence_check_top_test failed");
                $finish;
            end
        end
    end

    // sequence numbers biased towards the signed and unsigned extremes
    function automatic field_seq_t pick_seq();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return '1;
            4:       return field_seq_t'($urandom_range(1000));
            default: return field_seq_t'($urandom);
        endcase
    endfunction

    // well-formed received message, unused fields filled at random
    function automatic in_item_t msg_item(input logic [2:0] ty, input field_seq_t sn);
        in_item_t it;
        it.mode         = 1'b0;
        it.has_msg_code = 1'b1;
        it.msg_code     = ty;
        it.has_seq_num  = 1'b1;
        it.seq_num      = sn;
        it.has_new_seq  = 1'b0;
        it.new_seq      = field_seq_t'($urandom);
        it.poss_dup     = 1'($urandom_range(1));
        return it;
    endfunction

    // mostly in-session traffic, some gaps, stale numbers and noise
    function automatic in_item_t random_item();
        in_item_t   it;
        int         roll;
        logic [2:0] ty;
        it.mode         = 1'b0;
        it.has_msg_code = 1'($urandom_range(1));
        it.msg_code     = 3'($urandom_range(7));
        it.has_seq_num  = 1'($urandom_range(1));
        it.seq_num      = field_seq_t'($urandom);
        it.has_new_seq  = 1'($urandom_range(1));
        it.new_seq      = field_seq_t'($urandom);
        it.poss_dup     = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 8) begin
            it.mode = 1'b1;
        end else if (roll >= 14) begin
            if (!sess_on) begin
                ty = ($urandom_range(99) < 80) ? MSG_LOGON : 3'($urandom_range(7));
                it = msg_item(ty, pick_seq());
            end else begin
                roll = $urandom_range(99);
                ty   = 3'($urandom_range(7));
                if (ty == MSG_LOGOUT && $urandom_range(3) != 0)
                    ty = MSG_OTHER;
                if (roll < 70) begin
                    it = msg_item(ty, sess_next);
                    if (ty == MSG_SEQ_RESET) begin
                        it.has_new_seq = ($urandom_range(99) < 85);
                        it.new_seq = $urandom_range(1) ? pick_seq()
                                   : sess_next + field_seq_t'($urandom_range(20)) - 5;
                    end
                end else if (roll < 82) begin
                    it = msg_item(ty, $urandom_range(1) ? pick_seq()
                                      : sess_next + field_seq_t'($urandom_range(1000, 1)));
                end else if (roll < 95) begin
                    it = msg_item(ty, sess_next - field_seq_t'($urandom_range(50, 1)));
                end else begin
                    it = msg_item(ty, sess_next);
                    if ($urandom_range(1))
                        it.has_msg_code = 1'b0;
                    else
                        it.has_seq_num = 1'b0;
                end
            end
        end
        return it;
    endfunction

    // offer one item, idling first at random, and hold until taken
    task automatic send_item(input in_item_t it);
        if (!it.mode && it.has_msg_code && it.has_seq_num) begin
            if (!sess_on) begin
                if (it.msg_code == MSG_LOGON) begin
                    sess_on   = 1'b1;
                    sess_next = it.seq_num + 1'b1;
                end
            end else if (it.seq_num == sess_next) begin
                sess_next = sess_next + 1'b1;
                if (it.msg_code == MSG_SEQ_RESET && it.has_new_seq)
                    sess_next = it.new_seq;
                if (it.msg_code == MSG_LOGOUT)
                    sess_on = 1'b0;
            end
        end
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {1'b0, it.poss_dup, it.new_seq, it.has_new_seq, it.seq_num,
                     it.has_seq_num, it.msg_code, it.has_msg_code};
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender holds off until every result item is back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(random_item());
    endtask

    initial begin
        in_item_t it;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // sent events with all fields set, then message checks before logon
        it = '1;
        send_item(it);
        it = msg_item(MSG_LOGON, 5);
        it.has_msg_code = 1'b0;
        send_item(it);
        it = msg_item(MSG_LOGON, 5);
        it.has_seq_num = 1'b0;
        send_item(it);
        send_item(msg_item(MSG_HEARTBEAT, 1));

        // logon at the signed maximum, so the expected number wraps
        send_item(msg_item(MSG_LOGON, 32'h7FFF_FFFF));
        send_item(msg_item(MSG_HEARTBEAT, 32'h8000_0000));
        send_item(msg_item(MSG_TEST_REQ, 32'h8000_0001));
        send_item(msg_item(MSG_RESEND_REQ, 32'h8000_0002));
        send_item(msg_item(MSG_SEQ_RESET, 32'h8000_0003));
        it = msg_item(MSG_SEQ_RESET, 32'h8000_0004);
        it.has_new_seq = 1'b1;
        it.new_seq     = '1;
        send_item(it);
        send_item(msg_item(MSG_OTHER, '1));
        send_item(msg_item(MSG_UNLISTED, 0));
        // a second logon in order is application traffic
        send_item(msg_item(MSG_LOGON, 1));

        // gap, then stale numbers with and without the duplicate flag
        send_item(msg_item(MSG_HEARTBEAT, 32'h7FFF_FFFF));
        it = msg_item(MSG_HEARTBEAT, 32'h8000_0000);
        it.poss_dup = 1'b1;
        send_item(it);
        it = msg_item(MSG_OTHER, 1);
        it.poss_dup = 1'b0;
        send_item(it);
        it = '0;
        it.mode = 1'b1;
        send_item(it);

        // reset to the signed minimum: the signed maximum is now a gap
        it = msg_item(MSG_SEQ_RESET, 2);
        it.has_new_seq = 1'b1;
        it.new_seq     = 32'h8000_0000;
        send_item(it);
        send_item(msg_item(MSG_TEST_REQ, 32'h7FFF_FFFF));
        send_item(msg_item(MSG_HEARTBEAT, 32'h8000_0000));
        send_item(msg_item(MSG_LOGOUT, 32'h8000_0001));
        send_item(msg_item(MSG_TEST_REQ, 32'h8000_0002));
        it = msg_item(MSG_LOGON, 0);
        it.poss_dup = 1'b1;
        send_item(it);

        // random traffic under three idling patterns
        send_random(ITEMS_PER_PHASE);
        drain();
        tx_idle_pct  = 85;
        rx_stall_pct = 26;
        send_random(ITEMS_PER_PHASE);
        drain();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random(ITEMS_PER_PHASE);
        drain();
        repeat (8) @(posedge aclk);

        $display("run covered %0d items in and %0d result items compared",
                 items_in, results_out);
        $display("%0d of 15 reason codes seen across the session scenarios",
                 $countones(reasons_hit[14:0]));
        if (fail_count == 0 && pending == 0) begin
            $display("fix_session_sequence_check_top_test passed");
        end else begin
            $display("fix_session_sequence_check_top_test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fssc_pkg.sv
hw/rtl/fssc_in_reg.sv
hw/rtl/fssc_session.sv
hw/rtl/fix_session_sequence_check_top.sv
tb/sv/fssc_session_checker.sv
tb/sv/fix_session_sequence_check_top_test.sv
